// ----- rtl/ptfr_pkg.sv -----
package ptfr_pkg;

   localparam int MAX_PAYLOAD = 4;

   localparam logic [2:0] EV_NONE = 3'd0;
   localparam logic [2:0] EV_GOOD = 3'd1;
   localparam logic [2:0] EV_DUP  = 3'd2;
   localparam logic [2:0] EV_CRC  = 3'd3;
   localparam logic [2:0] EV_SYM  = 3'd4;

   localparam logic [2:0] REG_ZERO_MIN = 3'd0;
   localparam logic [2:0] REG_ZERO_MAX = 3'd1;
   localparam logic [2:0] REG_ONE_MIN  = 3'd2;
   localparam logic [2:0] REG_ONE_MAX  = 3'd3;
   localparam logic [2:0] REG_TWO_MIN  = 3'd4;
   localparam logic [2:0] REG_TWO_MAX  = 3'd5;
   localparam logic [2:0] REG_REPEAT   = 3'd6;

   localparam logic [2:0] REPEAT_AUTO  = 3'd5;

   typedef enum logic [2:0] {
      PH_SEARCH = 3'b001,
      PH_ZERO   = 3'b010,
      PH_DATA   = 3'b100
   } phase_type;

   typedef enum logic [3:0] {
      LG_HDR1 = 4'b0001,
      LG_HDR2 = 4'b0010,
      LG_DAT1 = 4'b0100,
      LG_DAT2 = 4'b1000
   } logic_phase_type;

   function automatic logic [3:0] crc_push(input logic [3:0] crc, input logic bit_in);
      logic [3:0] nxt;
      nxt = {crc[2:0], 1'b0};
      if (crc[3] ^ bit_in) nxt = nxt ^ 4'h3;
      return nxt;
   endfunction

endpackage

// ----- rtl/pulse_trit_frame_receiver.sv -----
// Pulse trit frame receiver.
// Input channel (req_valid/req_ready, req_pulse_width_us): one measured servo
// pulse width per transfer. Each width is classified into trit 0, 1 or 2,
// groups of samples are reduced by majority, a sync run of twos followed by
// zeros aligns the decoder, and trit pairs build header, payload and CRC.
// Result channel (rsp_valid/rsp_ready): exactly one result per input
// transfer, carrying the event code, frame bytes, length, sequence bit and
// repeat status.
// The result is in the output register in the cycle after the input transfer.
// Throughput: one item per cycle while the output register is free or its
// result is taken, with the output register as the single stage after decode.
// When the receiver stalls, the output register holds and req_ready drops
// only while a result is waiting and not being taken; a taken result frees
// the slot in the same cycle.
// Reset (synchronous, active high) restores the default windows, automatic
// repeat detection with count two, sync search and clears the last frame.
// A configuration write (csr_write_enable, csr_index, csr_write_data) must be
// issued while idle and returns the decoder to sync search.
module pulse_trit_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_pulse_width_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [31:0] rsp_frame_bytes,
   output logic [2:0]  rsp_frame_length,
   output logic        rsp_frame_sequence,
   output logic        rsp_majority_corrected,
   output logic        rsp_repeat_known,
   output logic [2:0]  rsp_repeat_in_use,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_write_data
);

   logic [11:0] win_lo_ff [3];
   logic [11:0] win_hi_ff [3];
   logic [2:0]  repeat_setting_ff;

   ptfr_pkg::phase_type       phase_ff, phase_in;
   logic [7:0]  run_ff, run_in;
   logic [2:0]  zsamp_ff, zsamp_in, zhits_ff, zhits_in;
   logic [2:0]  gsamp_ff, gsamp_in;
   logic [2:0]  gcnt_ff [3];
   logic [2:0]  gcnt_in [3];
   ptfr_pkg::logic_phase_type lphase_ff, lphase_in;
   logic [1:0]  held_ff, held_in;
   logic        cseq_ff, cseq_in;
   logic [2:0]  clen_ff, clen_in;
   logic [7:0]  pay_ff [4];
   logic [7:0]  pay_in [4];
   logic [1:0]  bytepos_ff, bytepos_in;
   logic [2:0]  bitpos_ff, bitpos_in;
   logic [3:0]  crc_ff, crc_in, crcr_ff, crcr_in;
   logic [5:0]  done_ff, done_in, total_ff, total_in;
   logic [2:0]  rcount_ff, rcount_in;
   logic        rfound_ff, rfound_in;
   logic        pvalid_ff, pvalid_in, pseq_ff, pseq_in;
   logic [2:0]  plen_ff, plen_in;
   logic [7:0]  ppay_ff [4];
   logic [7:0]  ppay_in [4];

   logic        out_valid_ff;
   logic [2:0]  out_ev_ff, ev;
   logic [31:0] out_bytes_ff, bytes_v;
   logic [2:0]  out_len_ff, len_v;
   logic        out_seq_ff, seq_v, out_corr_ff, corr_v;
   logic [2:0]  out_rc_ff;
   logic        out_rf_ff;

   logic        take;
   assign req_ready = !out_valid_ff || rsp_ready;
   assign take = req_valid && req_ready;

   logic        t_valid;
   logic [1:0]  t_val;
   always_comb begin
      t_valid = 1'b0;
      t_val = 2'd0;
      for (int t = 2; t >= 0; t--) begin
         if (req_pulse_width_us >= win_lo_ff[t] && req_pulse_width_us <= win_hi_ff[t]) begin
            t_valid = 1'b1;
            t_val = 2'(t);
         end
      end
   end

   logic [2:0] spt_m1;
   logic [2:0] need_maj;
   logic [3:0] spt;
   assign spt_m1 = rcount_ff;
   assign spt = {1'b0, rcount_ff} + 4'd1;
   assign need_maj = 3'(spt >> 1) + 3'd1;

   always_comb begin
      logic sync_back, do_start, found;
      logic [2:0] best, new_rc, nm;
      logic [3:0] nspt;
      logic [7:0] e, d;
      logic [7:0] need;
      logic [2:0] gs;
      logic [2:0] cnt [3];
      logic       winf;
      logic [1:0] win;
      logic [3:0] v;
      logic [2:0] vb;
      logic       dup;
      logic [3:0] c;
      logic       fin, bitv;

      phase_in = phase_ff; run_in = run_ff; zsamp_in = zsamp_ff; zhits_in = zhits_ff;
      gsamp_in = gsamp_ff; gcnt_in = gcnt_ff; lphase_in = lphase_ff; held_in = held_ff;
      cseq_in = cseq_ff; clen_in = clen_ff; pay_in = pay_ff; bytepos_in = bytepos_ff;
      bitpos_in = bitpos_ff; crc_in = crc_ff; crcr_in = crcr_ff; done_in = done_ff;
      total_in = total_ff; rcount_in = rcount_ff; rfound_in = rfound_ff;
      pvalid_in = pvalid_ff; pseq_in = pseq_ff; plen_in = plen_ff; ppay_in = ppay_ff;
      ev = ptfr_pkg::EV_NONE; seq_v = 1'b0; corr_v = 1'b0;
      sync_back = 1'b0; do_start = 1'b0; found = 1'b0; best = 3'd0;
      e = 8'd0; d = 8'd0; need = 8'd0; gs = 3'd0; cnt = gcnt_ff; winf = 1'b0;
      win = 2'd0; v = 4'd0; vb = 3'd0; dup = 1'b0; c = crc_ff; fin = 1'b0; bitv = 1'b0;
      new_rc = rcount_ff; nm = need_maj; nspt = spt;

      case (phase_ff)
         ptfr_pkg::PH_SEARCH: begin
            if (t_valid && t_val == 2'd2) begin
               if (run_ff != 8'd255) run_in = run_ff + 8'd1;
            end else if (t_valid && t_val == 2'd0) begin
               if (repeat_setting_ff == ptfr_pkg::REPEAT_AUTO) begin
                  for (int r = 4; r >= 0; r--) begin
                     e = 8'(3 * (r + 1));
                     d = (run_ff > e) ? run_ff - e : e - run_ff;
                     if (d <= 8'd1) begin
                        found = 1'b1;
                        best = 3'(r);
                     end
                  end
                  if (found) begin
                     rcount_in = best;
                     rfound_in = 1'b1;
                     new_rc = best;
                     do_start = 1'b1;
                  end else begin
                     run_in = 8'd0;
                  end
               end else begin
                  need = (spt_m1 != 3'd0) ? 8'(3 * spt - 2) : 8'd3;
                  if (run_ff >= need) do_start = 1'b1;
                  else run_in = 8'd0;
               end
            end else begin
               run_in = 8'd0;
            end
            if (do_start) begin
               zsamp_in = 3'd1;
               zhits_in = 3'd1;
               if (new_rc == 3'd0) begin
                  gsamp_in = 3'd0;
                  for (int i = 0; i < 3; i++) gcnt_in[i] = 3'd0;
                  lphase_in = ptfr_pkg::LG_HDR1;
                  phase_in = ptfr_pkg::PH_DATA;
               end else begin
                  phase_in = ptfr_pkg::PH_ZERO;
               end
            end
         end
         ptfr_pkg::PH_ZERO: begin
            zsamp_in = zsamp_ff + 3'd1;
            zhits_in = zhits_ff + ((t_valid && t_val == 2'd0) ? 3'd1 : 3'd0);
            if ({1'b0, zsamp_in} >= nspt) begin
               if (zhits_in >= nm) begin
                  gsamp_in = 3'd0;
                  for (int i = 0; i < 3; i++) gcnt_in[i] = 3'd0;
                  lphase_in = ptfr_pkg::LG_HDR1;
                  phase_in = ptfr_pkg::PH_DATA;
               end else begin
                  ev = ptfr_pkg::EV_SYM;
                  sync_back = 1'b1;
               end
            end
         end
         ptfr_pkg::PH_DATA: begin
            gs = gsamp_ff + 3'd1;
            gsamp_in = gs;
            if (t_valid) cnt[t_val] = gcnt_ff[t_val] + 3'd1;
            gcnt_in = cnt;
            if ({1'b0, gs} >= nspt) begin
               for (int i = 2; i >= 0; i--) begin
                  if (cnt[i] >= nm) begin
                     winf = 1'b1;
                     win = 2'(i);
                  end
               end
               if (!winf) begin
                  ev = ptfr_pkg::EV_SYM;
                  sync_back = 1'b1;
               end else begin
                  if ({1'b0, cnt[win]} != nspt) corr_v = 1'b1;
                  gsamp_in = 3'd0;
                  for (int i = 0; i < 3; i++) gcnt_in[i] = 3'd0;
                  if (lphase_ff == ptfr_pkg::LG_HDR1 || lphase_ff == ptfr_pkg::LG_DAT1) begin
                     held_in = win;
                     lphase_in = (lphase_ff == ptfr_pkg::LG_HDR1) ?
                                 ptfr_pkg::LG_HDR2 : ptfr_pkg::LG_DAT2;
                  end else begin
                     v = {held_ff, 1'b0} + {2'b00, held_ff} + {2'b00, win};
                     vb = v[2:0];
                     if (v > 4'd7) begin
                        ev = ptfr_pkg::EV_SYM;
                        sync_back = 1'b1;
                     end else if (lphase_ff == ptfr_pkg::LG_HDR2) begin
                        cseq_in = vb[2];
                        clen_in = {1'b0, vb[1:0]} + 3'd1;
                        if (clen_in > 3'(ptfr_pkg::MAX_PAYLOAD)) begin
                           ev = ptfr_pkg::EV_SYM;
                           sync_back = 1'b1;
                        end else begin
                           for (int i = 0; i < 4; i++) pay_in[i] = 8'd0;
                           bytepos_in = 2'd0;
                           bitpos_in = 3'd0;
                           crcr_in = 4'd0;
                           done_in = 6'd0;
                           total_in = {clen_in, 3'b000} + 6'd4;
                           c = 4'hF;
                           for (int b = 2; b >= 0; b--) c = ptfr_pkg::crc_push(c, vb[b]);
                           crc_in = c;
                           lphase_in = ptfr_pkg::LG_DAT1;
                        end
                     end else begin
                        lphase_in = ptfr_pkg::LG_DAT1;
                        for (int b = 2; b >= 0; b--) begin
                           if (!fin && done_in < total_in) begin
                              bitv = vb[b];
                              if (done_in < {clen_ff, 3'b000}) begin
                                 pay_in[bytepos_in] = {pay_in[bytepos_in][6:0], bitv};
                                 crc_in = ptfr_pkg::crc_push(crc_in, bitv);
                                 if (bitpos_in == 3'd7) begin
                                    bitpos_in = 3'd0;
                                    bytepos_in = bytepos_in + 2'd1;
                                 end else begin
                                    bitpos_in = bitpos_in + 3'd1;
                                 end
                              end else begin
                                 crcr_in = {crcr_in[2:0], bitv};
                              end
                              done_in = done_in + 6'd1;
                              if (done_in >= total_in) fin = 1'b1;
                           end
                        end
                        if (fin) begin
                           seq_v = cseq_ff;
                           if (crc_in != crcr_in) begin
                              ev = ptfr_pkg::EV_CRC;
                           end else begin
                              dup = pvalid_ff && pseq_ff == cseq_ff && plen_ff == clen_ff;
                              for (int i = 0; i < 4; i++)
                                 if (3'(i) < clen_ff && pay_in[i] != ppay_ff[i]) dup = 1'b0;
                              if (dup) begin
                                 ev = ptfr_pkg::EV_DUP;
                              end else begin
                                 ev = ptfr_pkg::EV_GOOD;
                                 pvalid_in = 1'b1;
                                 pseq_in = cseq_ff;
                                 plen_in = clen_ff;
                                 for (int i = 0; i < 4; i++)
                                    if (3'(i) < clen_ff) ppay_in[i] = pay_in[i];
                              end
                           end
                           sync_back = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         default: sync_back = 1'b1;
      endcase

      if (sync_back) begin
         phase_in = ptfr_pkg::PH_SEARCH; run_in = 8'd0; zsamp_in = 3'd0; zhits_in = 3'd0;
         gsamp_in = 3'd0;
         for (int i = 0; i < 3; i++) gcnt_in[i] = 3'd0;
         lphase_in = ptfr_pkg::LG_HDR1; held_in = 2'd0; cseq_in = 1'b0; clen_in = 3'd0;
         for (int i = 0; i < 4; i++) pay_in[i] = 8'd0;
         bytepos_in = 2'd0; bitpos_in = 3'd0; crc_in = 4'hF; crcr_in = 4'd0;
         done_in = 6'd0; total_in = 6'd0;
      end

      bytes_v = 32'd0;
      len_v = 3'd0;
      if (ev == ptfr_pkg::EV_GOOD) begin
         len_v = plen_in;
         for (int i = 0; i < 4; i++)
            if (3'(i) < plen_in) bytes_v[8*i +: 8] = ppay_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_lo_ff[0] <= 12'd800;  win_hi_ff[0] <= 12'd1200;
         win_lo_ff[1] <= 12'd1300; win_hi_ff[1] <= 12'd1700;
         win_lo_ff[2] <= 12'd1800; win_hi_ff[2] <= 12'd2200;
         repeat_setting_ff <= ptfr_pkg::REPEAT_AUTO;
         rcount_ff <= 3'd2; rfound_ff <= 1'b0;
         pvalid_ff <= 1'b0; pseq_ff <= 1'b0; plen_ff <= 3'd0;
         for (int i = 0; i < 4; i++) ppay_ff[i] <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable && csr_index <= ptfr_pkg::REG_REPEAT) begin
            case (csr_index)
               ptfr_pkg::REG_ZERO_MIN: win_lo_ff[0] <= csr_write_data;
               ptfr_pkg::REG_ZERO_MAX: win_hi_ff[0] <= csr_write_data;
               ptfr_pkg::REG_ONE_MIN:  win_lo_ff[1] <= csr_write_data;
               ptfr_pkg::REG_ONE_MAX:  win_hi_ff[1] <= csr_write_data;
               ptfr_pkg::REG_TWO_MIN:  win_lo_ff[2] <= csr_write_data;
               ptfr_pkg::REG_TWO_MAX:  win_hi_ff[2] <= csr_write_data;
               default: begin
                  repeat_setting_ff <= csr_write_data[2:0];
                  if (csr_write_data[2:0] == ptfr_pkg::REPEAT_AUTO) begin
                     rfound_ff <= 1'b0;
                  end else begin
                     rfound_ff <= 1'b1;
                     rcount_ff <= (csr_write_data[2:0] > 3'd4) ? 3'd4 : csr_write_data[2:0];
                  end
               end
            endcase
         end else if (take) begin
            rcount_ff <= rcount_in; rfound_ff <= rfound_in;
            pvalid_ff <= pvalid_in; pseq_ff <= pseq_in; plen_ff <= plen_in;
            ppay_ff <= ppay_in;
         end
         if (take && !(csr_write_enable && csr_index <= ptfr_pkg::REG_REPEAT)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_valid && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (csr_write_enable && csr_index <= ptfr_pkg::REG_REPEAT)) begin
         phase_ff <= ptfr_pkg::PH_SEARCH; run_ff <= 8'd0; zsamp_ff <= 3'd0; zhits_ff <= 3'd0;
         gsamp_ff <= 3'd0;
         for (int i = 0; i < 3; i++) gcnt_ff[i] <= 3'd0;
         lphase_ff <= ptfr_pkg::LG_HDR1; held_ff <= 2'd0; cseq_ff <= 1'b0; clen_ff <= 3'd0;
         for (int i = 0; i < 4; i++) pay_ff[i] <= 8'd0;
         bytepos_ff <= 2'd0; bitpos_ff <= 3'd0; crc_ff <= 4'hF; crcr_ff <= 4'd0;
         done_ff <= 6'd0; total_ff <= 6'd0;
      end else if (take) begin
         phase_ff <= phase_in; run_ff <= run_in; zsamp_ff <= zsamp_in; zhits_ff <= zhits_in;
         gsamp_ff <= gsamp_in; gcnt_ff <= gcnt_in; lphase_ff <= lphase_in; held_ff <= held_in;
         cseq_ff <= cseq_in; clen_ff <= clen_in; pay_ff <= pay_in; bytepos_ff <= bytepos_in;
         bitpos_ff <= bitpos_in; crc_ff <= crc_in; crcr_ff <= crcr_in; done_ff <= done_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ev_ff <= ev; out_bytes_ff <= bytes_v; out_len_ff <= len_v;
         out_seq_ff <= seq_v; out_corr_ff <= corr_v;
         out_rc_ff <= rcount_in; out_rf_ff <= rfound_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_event_res = out_ev_ff;
   assign rsp_frame_bytes = out_bytes_ff;
   assign rsp_frame_length = out_len_ff;
   assign rsp_frame_sequence = out_seq_ff;
   assign rsp_majority_corrected = out_corr_ff;
   assign rsp_repeat_known = out_rf_ff;
   assign rsp_repeat_in_use = out_rc_ff;

`ifndef SYNTHESIS
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("ready low with empty output");
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid) else $error("result missing");
   a_len_only_good: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res != ptfr_pkg::EV_GOOD) |-> rsp_frame_length == 3'd0)
      else $error("length on non-good event");
   a_rc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_in_use <= 3'd4) else $error("repeat out of range");
`endif

endmodule

// ----- sim/pulse_trit_frame_receiver_tb.sv -----
module pulse_trit_frame_receiver_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] frame_bytes;
      logic [2:0]  frame_length;
      logic        frame_sequence;
      logic        majority_corrected;
      logic        repeat_known;
      logic [2:0]  repeat_in_use;
   } frame_report_type;

   localparam int LIMIT_CYCLES = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [11:0] req_pulse_width_us;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_event_res;
   logic [31:0] rsp_frame_bytes;
   logic [2:0]  rsp_frame_length;
   logic        rsp_frame_sequence;
   logic        rsp_majority_corrected;
   logic        rsp_repeat_known;
   logic [2:0]  rsp_repeat_in_use;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [11:0] csr_write_data;

   pulse_trit_frame_receiver dut (.*);

   // decoder copy
   logic [11:0] win_lo [3];
   logic [11:0] win_hi [3];
   logic [2:0]  rep_mode;
   int unsigned phys, run_len, zg_samples, zg_hits, grp_samples;
   int unsigned trit_votes [3];
   int unsigned lphase, held_trit, cur_seq, cur_len, byte_pos, bit_pos;
   logic [7:0]  payload [4];
   logic [3:0]  crc_acc, crc_rx;
   int unsigned bits_done, bits_total, rep_count;
   logic        rep_found, last_valid, last_seq;
   int unsigned last_len;
   logic [7:0]  last_payload [4];
   logic [2:0]  ev_code;
   logic        ev_seq, ev_fix;

   logic [11:0]      pending_widths [$];
   frame_report_type expected_reports [$];
   int               mismatches;
   int               cycle_count;
   bit               stall_rx;
   int               hold_cycles;
   bit               quiet_mode;
   bit               done;

   function automatic logic [3:0] crc_step(logic [3:0] c, logic b);
      logic [3:0] n;
      n = {c[2:0], 1'b0};
      if (c[3] ^ b) n ^= 4'h3;
      return n;
   endfunction

   function automatic void resync();
      phys = 0; run_len = 0; zg_samples = 0; zg_hits = 0; grp_samples = 0;
      trit_votes = '{0, 0, 0};
      lphase = 0; held_trit = 0; cur_seq = 0; cur_len = 0;
      payload = '{0, 0, 0, 0};
      byte_pos = 0; bit_pos = 0; crc_acc = 4'hF; crc_rx = 0;
      bits_done = 0; bits_total = 0;
   endfunction

   function automatic void reset_decoder();
      win_lo = '{800, 1300, 1800};
      win_hi = '{1200, 1700, 2200};
      rep_mode = ptfr_pkg::REPEAT_AUTO; rep_count = 2; rep_found = 0;
      last_valid = 0; last_seq = 0; last_len = 0;
      last_payload = '{0, 0, 0, 0};
      resync();
   endfunction

   function automatic void apply_csr(logic [2:0] idx, logic [11:0] val);
      if (idx <= ptfr_pkg::REG_TWO_MAX) begin
         if (idx[0]) win_hi[idx >> 1] = val;
         else win_lo[idx >> 1] = val;
      end else if (idx == ptfr_pkg::REG_REPEAT) begin
         rep_mode = val[2:0];
         if (rep_mode == ptfr_pkg::REPEAT_AUTO) rep_found = 0;
         else begin
            rep_count = rep_mode > 4 ? 4 : rep_mode;
            rep_found = 1;
         end
      end else return;
      resync();
   endfunction

   function automatic void finish_frame();
      bit dup;
      ev_seq = cur_seq;
      if (crc_acc != crc_rx) ev_code = ptfr_pkg::EV_CRC;
      else begin
         dup = last_valid && last_seq == cur_seq && last_len == cur_len;
         for (int i = 0; i < cur_len; i++)
            if (payload[i] != last_payload[i]) dup = 0;
         if (dup) ev_code = ptfr_pkg::EV_DUP;
         else begin
            ev_code = ptfr_pkg::EV_GOOD;
            last_valid = 1; last_seq = cur_seq; last_len = cur_len;
            for (int i = 0; i < cur_len; i++) last_payload[i] = payload[i];
         end
      end
      resync();
   endfunction

   function automatic void take_bit(logic b);
      if (bits_done < cur_len * 8) begin
         payload[byte_pos & 3] = {payload[byte_pos & 3][6:0], b};
         bit_pos++;
         crc_acc = crc_step(crc_acc, b);
         if (bit_pos == 8) begin
            bit_pos = 0;
            byte_pos++;
         end
      end else crc_rx = {crc_rx[2:0], b};
      bits_done++;
      if (bits_done >= bits_total) finish_frame();
   endfunction

   function automatic void take_trit(int unsigned t);
      logic [3:0] v;
      if (lphase == 0 || lphase == 2) begin
         held_trit = t;
         lphase++;
         return;
      end
      v = 4'(held_trit * 3 + t);
      if (v > 7) begin
         ev_code = ptfr_pkg::EV_SYM;
         resync();
         return;
      end
      if (lphase == 1) begin
         cur_seq = v[2];
         cur_len = v[1:0] + 1;
         payload = '{0, 0, 0, 0};
         byte_pos = 0; bit_pos = 0; crc_rx = 0; bits_done = 0;
         bits_total = cur_len * 8 + 4;
         crc_acc = 4'hF;
         for (int b = 2; b >= 0; b--) crc_acc = crc_step(crc_acc, v[b]);
         lphase = 2;
      end else begin
         lphase = 2;
         for (int b = 2; b >= 0; b--) begin
            if (bits_done >= bits_total) return;
            take_bit(v[b]);
         end
      end
   endfunction

   function automatic void enter_zero_group();
      zg_samples = 1; zg_hits = 1;
      if (rep_count == 0) begin
         grp_samples = 0; trit_votes = '{0, 0, 0};
         lphase = 0; phys = 2;
      end else phys = 1;
   endfunction

   function automatic frame_report_type predict_report(logic [11:0] w);
      frame_report_type r;
      int t, win, need, spt, e, d;
      ev_code = ptfr_pkg::EV_NONE; ev_seq = 0; ev_fix = 0;
      t = -1;
      for (int i = 2; i >= 0; i--)
         if (w >= win_lo[i] && w <= win_hi[i]) t = i;
      spt = rep_count + 1;
      need = spt / 2 + 1;
      if (phys == 0) begin
         if (t == 2) begin
            if (run_len < 255) run_len++;
         end else if (t == 0) begin
            if (rep_mode == ptfr_pkg::REPEAT_AUTO) begin
               win = -1;
               for (int r = 4; r >= 0; r--) begin
                  e = 3 * (r + 1);
                  d = run_len > e ? run_len - e : e - run_len;
                  if (d <= 1) win = r;
               end
               if (win >= 0) begin
                  rep_count = win; rep_found = 1;
                  enter_zero_group();
               end else run_len = 0;
            end else begin
               if (run_len >= (spt > 1 ? 3 * spt - 2 : 3)) enter_zero_group();
               else run_len = 0;
            end
         end else run_len = 0;
      end else if (phys == 1) begin
         zg_samples++;
         if (t == 0) zg_hits++;
         if (zg_samples >= spt) begin
            if (zg_hits >= need) begin
               grp_samples = 0; trit_votes = '{0, 0, 0};
               lphase = 0; phys = 2;
            end else begin
               ev_code = ptfr_pkg::EV_SYM;
               resync();
            end
         end
      end else begin
         grp_samples++;
         if (t >= 0) trit_votes[t]++;
         if (grp_samples >= spt) begin
            win = -1;
            for (int i = 2; i >= 0; i--) if (trit_votes[i] >= need) win = i;
            if (win < 0) begin
               ev_code = ptfr_pkg::EV_SYM;
               resync();
            end else begin
               if (trit_votes[win] != spt) ev_fix = 1;
               grp_samples = 0; trit_votes = '{0, 0, 0};
               take_trit(win);
            end
         end
      end
      r = '0;
      r.event_res = ev_code;
      if (ev_code == ptfr_pkg::EV_GOOD) begin
         r.frame_length = 3'(last_len);
         for (int i = 0; i < last_len; i++) r.frame_bytes[8*i +: 8] = last_payload[i];
      end
      r.frame_sequence = ev_seq;
      r.majority_corrected = ev_fix;
      r.repeat_known = rep_found;
      r.repeat_in_use = 3'(rep_count);
      return r;
   endfunction

   // stimulus building
   function automatic logic [11:0] width_of(int unsigned t);
      case (t)
         0: return 12'($urandom_range(win_lo[0], win_hi[0]));
         1: return 12'($urandom_range(win_lo[1], win_hi[1]));
         2: return 12'($urandom_range(win_lo[2], win_hi[2]));
         default: return 12'($urandom_range(2300, 4095));
      endcase
   endfunction

   function automatic void push_trit(int unsigned t, int unsigned spt, bit noisy);
      for (int i = 0; i < spt; i++) begin
         if (noisy && i == 0 && spt >= 3) pending_widths.push_back(width_of($urandom_range(0, 3)));
         else pending_widths.push_back(width_of(t));
      end
   endfunction

   function automatic void push_frame(int unsigned rep, logic seq, int unsigned len,
                                      logic [31:0] data, bit bad_crc, bit noisy);
      logic [3:0] crc;
      logic       bits [$];
      logic [2:0] v;
      for (int i = 0; i < 3 * (rep + 1); i++) pending_widths.push_back(width_of(2));
      push_trit(0, rep + 1, 0);
      v = {seq, 2'(len - 1)};
      crc = 4'hF;
      for (int b = 2; b >= 0; b--) crc = crc_step(crc, v[b]);
      push_trit(v / 3, rep + 1, 0);
      push_trit(v % 3, rep + 1, 0);
      for (int i = 0; i < len; i++)
         for (int b = 7; b >= 0; b--) begin
            bits.push_back(data[8*i + b]);
            crc = crc_step(crc, data[8*i + b]);
         end
      if (bad_crc) crc ^= 4'(1 << $urandom_range(0, 3));
      for (int b = 3; b >= 0; b--) bits.push_back(crc[b]);
      while (bits.size() % 3 != 0) bits.push_back($urandom_range(0, 1));
      while (bits.size() > 0) begin
         v[2] = bits.pop_front();
         v[1] = bits.pop_front();
         v[0] = bits.pop_front();
         push_trit(v / 3, rep + 1, noisy && $urandom_range(0, 3) == 0);
         push_trit(v % 3, rep + 1, noisy && $urandom_range(0, 3) == 0);
      end
   endfunction

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_pulse_width_us <= '0;
      end else if (!req_valid || req_ready) begin
         if (pending_widths.size() > 0 && (quiet_mode || $urandom_range(0, 99) >= 20)) begin
            req_valid <= 1;
            req_pulse_width_us <= pending_widths.pop_front();
         end else req_valid <= 0;
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_cycles > 0) begin
         rsp_ready <= 0;
         hold_cycles <= hold_cycles - 1;
      end else if (stall_rx) begin
         rsp_ready <= 0;
         hold_cycles <= 60;
         stall_rx <= 0;
      end else rsp_ready <= quiet_mode || $urandom_range(0, 99) >= 20;
   end

   // monitor
   always @(posedge clock) begin
      frame_report_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && req_ready)
         expected_reports.push_back(predict_report(req_pulse_width_us));
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_event_res, rsp_frame_bytes, rsp_frame_length, rsp_frame_sequence,
                rsp_majority_corrected, rsp_repeat_known, rsp_repeat_in_use};
         if (expected_reports.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result %h", got);
         end else begin
            want = expected_reports.pop_front();
            if (got !== want) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: exp ev=%0d bytes=%h len=%0d seq=%0d fix=%0d known=%0d rep=%0d got ev=%0d bytes=%h len=%0d seq=%0d fix=%0d known=%0d rep=%0d",
                           want.event_res, want.frame_bytes, want.frame_length,
                           want.frame_sequence, want.majority_corrected,
                           want.repeat_known, want.repeat_in_use,
                           got.event_res, got.frame_bytes, got.frame_length,
                           got.frame_sequence, got.majority_corrected,
                           got.repeat_known, got.repeat_in_use);
            end
         end
      end
      if (cycle_count > LIMIT_CYCLES && !done) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic drain();
      while (pending_widths.size() > 0 || req_valid || expected_reports.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [11:0] val);
      drain();
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      apply_csr(idx, val);
   endtask

   task automatic random_phase(int unsigned frames, int unsigned rep);
      logic [31:0] d;
      for (int f = 0; f < frames; f++) begin
         case ($urandom_range(0, 9))
            0: for (int i = 0; i < 6; i++) pending_widths.push_back(12'($urandom_range(0, 4095)));
            1: begin
               push_frame(rep, $urandom_range(0, 1), $urandom_range(1, 4), $urandom, 0, 0);
               pending_widths = pending_widths[0:$ - $urandom_range(1, 8)];
            end
            2: push_frame(rep, last_seq, last_len == 0 ? 1 : last_len,
                          {last_payload[3], last_payload[2], last_payload[1], last_payload[0]},
                          0, 0);
            default: begin
               d = $urandom;
               push_frame(rep, $urandom_range(0, 1), $urandom_range(1, 4), d,
                          $urandom_range(0, 5) == 0, $urandom_range(0, 2) == 0);
            end
         endcase
      end
   endtask

   initial begin
      reset = 1;
      csr_write_enable = 0;
      csr_index = '0;
      csr_write_data = '0;
      mismatches = 0;
      cycle_count = 0;
      stall_rx = 0;
      hold_cycles = 0;
      quiet_mode = 0;
      done = 0;
      reset_decoder();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: width extremes, auto sync, duplicate, crc error, illegal pair
      pending_widths.push_back(12'd0);
      pending_widths.push_back(12'hFFF);
      pending_widths.push_back(12'hAAA);
      pending_widths.push_back(12'h555);
      push_frame(2, 1, 4, 32'hA5C3_0FF0, 0, 0);
      push_frame(2, 1, 4, 32'hA5C3_0FF0, 0, 0);
      push_frame(2, 0, 1, 32'h0000_0081, 1, 0);
      for (int i = 0; i < 9; i++) pending_widths.push_back(width_of(2));
      push_trit(0, 3, 0);
      push_trit(2, 3, 0);
      push_trit(2, 3, 0);
      drain();
      random_phase(3, 2);
      stall_rx <= 1;
      random_phase(2, 2);
      write_csr(ptfr_pkg::REG_REPEAT, 0);
      random_phase(3, 0);
      write_csr(ptfr_pkg::REG_REPEAT, 4);
      quiet_mode <= 1;
      random_phase(2, 4);
      drain();
      quiet_mode <= 0;
      write_csr(ptfr_pkg::REG_REPEAT, 7);
      random_phase(1, 4);
      write_csr(ptfr_pkg::REG_REPEAT, ptfr_pkg::REPEAT_AUTO);
      random_phase(2, 0);
      random_phase(1, 4);
      write_csr(ptfr_pkg::REG_ZERO_MIN, 0);
      write_csr(ptfr_pkg::REG_ZERO_MAX, 1000);
      write_csr(ptfr_pkg::REG_ONE_MIN, 1001);
      write_csr(ptfr_pkg::REG_ONE_MAX, 2000);
      write_csr(ptfr_pkg::REG_TWO_MIN, 2001);
      write_csr(ptfr_pkg::REG_TWO_MAX, 4095);
      write_csr(ptfr_pkg::REG_REPEAT, 1);
      random_phase(2, 1);
      write_csr(ptfr_pkg::REG_REPEAT, 3);
      random_phase(1, 3);
      write_csr(ptfr_pkg::REG_TWO_MAX, 12'hFFF);
      write_csr(ptfr_pkg::REG_ONE_MIN, 12'hFFF);
      write_csr(ptfr_pkg::REG_REPEAT, ptfr_pkg::REPEAT_AUTO);
      for (int i = 0; i < 40; i++) pending_widths.push_back(12'($urandom_range(0, 4095)));
      drain();
      repeat (10) @(posedge clock);
      done = 1;
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ptfr_pkg.sv
rtl/pulse_trit_frame_receiver.sv
sim/pulse_trit_frame_receiver_tb.sv
